// ===== rtl/tls_client_hello_sni_extract_core_assert.svh =====
// Assertion macros shared by the SNI extractor modules.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACT_CORE_ASSERT_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TLSSNI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TLSSNI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlssni_pkg.sv =====
// Types and constants shared by the TLS ClientHello SNI extractor.
`timescale 1ns / 1ps
package tlssni_pkg;

    localparam int PHASE_W = 18;

    typedef enum logic [PHASE_W-1:0] {
        PH_TYPE     = 18'd1,
        PH_MAJOR    = 18'd2,
        PH_HDR_REST = 18'd4,
        PH_HS_TYPE  = 18'd8,
        PH_FIXED    = 18'd16,
        PH_SID_LEN  = 18'd32,
        PH_SID_SKIP = 18'd64,
        PH_CS_LEN   = 18'd128,
        PH_CS_SKIP  = 18'd256,
        PH_CM_LEN   = 18'd512,
        PH_CM_SKIP  = 18'd1024,
        PH_EXT_LEN  = 18'd2048,
        PH_EXT_HDR  = 18'd4096,
        PH_EXT_SKIP = 18'd8192,
        PH_SNI_HDR  = 18'd16384,
        PH_SNI_LEN  = 18'd32768,
        PH_NAME     = 18'd65536,
        PH_DONE     = 18'd131072
    } phase_t;

    localparam logic [7:0]  REC_TYPE_HANDSHAKE = 8'h16;
    localparam logic [7:0]  REC_MAJOR_VERSION  = 8'h03;
    localparam logic [7:0]  HS_CLIENT_HELLO    = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME    = 16'h0000;
    // record version minor + record length
    localparam logic [15:0] HDR_REST_BYTES     = 16'd3;
    // handshake length (3) + client version (2) + random (32)
    localparam logic [15:0] FIXED_BYTES        = 16'd37;
    localparam logic [15:0] MAX_NAME_BYTES     = 16'd255;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_byte;
        logic       sni_found;
        logic [7:0] sni_length;
        logic       truncated;
        logic       is_last;
    } out_item_t;

    // Up to two results per byte; r1 is only used when r0 is used.
    typedef struct packed {
        logic      v0;
        logic      v1;
        out_item_t r0;
        out_item_t r1;
    } res_pair_t;

endpackage

// ===== rtl/tls_client_hello_sni_extract_core.sv =====
// Top level of the TLS ClientHello server-name extractor.
`timescale 1ns / 1ps
// Packet bytes enter on the slave stream, one transaction per byte, tlast on
// the final byte. Each accepted byte runs through a one-hot parse state
// machine that checks the record header (type 0x16, major version 3) and the
// client hello handshake type, skips the fixed fields, session id, cipher
// suites and compression methods, and walks the extension list to the
// server-name extension. Name bytes of up to 255 characters are sent out as
// they arrive (tuser 0); the final byte of every packet yields a summary
// transaction (tuser 1, tlast 1) with the found flag, declared length and a
// truncated flag, and rearms the parser. Results pass through a four-entry
// queue: s_axis_tready is high while it holds two entries or fewer, so bytes
// flow at one per cycle, each result registered in the queue, whenever the
// master side keeps up. The master side moves one transaction per cycle while
// m_axis_tready is high; a packet whose last byte is also a name byte
// produces two results, which costs an extra output transaction.
module tls_client_hello_sni_extract_core
    import tlssni_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] name_byte, [8] sni_found,
                                        // [16:9] sni_length, [17] truncated, [23:18] zero
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // is_last
);

    logic      in_accept;
    logic      room;
    res_pair_t res;
    out_item_t head;

    // Accept a byte whenever the queue can absorb two results.
    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && room;

    tlssni_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_accept),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .res      (res)
    );

    tlssni_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (head)
    );

    // Pack the head result onto the master stream.
    assign m_axis_tdata = {6'd0, head.truncated, head.sni_length, head.sni_found,
                           head.name_byte};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.is_last;

endmodule

// ===== rtl/tlssni_parser.sv =====
// Per-byte ClientHello parse state machine producing name bytes and summaries.
`timescale 1ns / 1ps
`include "tls_client_hello_sni_extract_core_assert.svh"
module tlssni_parser
    import tlssni_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output res_pair_t  res
);

    phase_t      phase_reg, phase_next, phase_step;
    logic [1:0]  bpos_reg, bpos_next, bpos_step;
    logic [15:0] skip_reg, skip_next, skip_step;
    logic [15:0] acc_reg, acc_next, acc_step;
    logic [15:0] ext_reg, ext_next, ext_step;
    logic [7:0]  nleft_reg, nleft_next, nleft_step;
    logic [7:0]  nlen_reg, nlen_next, nlen_step;
    logic        found_reg, found_next, found_step;
    logic        emit_name;

    logic [15:0] acc_sh, ext_sh, skip_sh, ext_dec, skip_dec;
    logic [7:0]  nleft_dec;

    assign acc_sh    = {acc_reg[7:0], in_byte};
    assign ext_sh    = {ext_reg[7:0], in_byte};
    assign skip_sh   = {skip_reg[7:0], in_byte};
    assign ext_dec   = ext_reg - 16'd1;
    assign skip_dec  = skip_reg - 16'd1;
    assign nleft_dec = nleft_reg - 8'd1;

    always_comb
    begin
        phase_step = phase_reg;
        bpos_step  = bpos_reg;
        skip_step  = skip_reg;
        acc_step   = acc_reg;
        ext_step   = ext_reg;
        nleft_step = nleft_reg;
        nlen_step  = nlen_reg;
        found_step = found_reg;
        emit_name  = 1'b0;
        unique case (phase_reg)
            PH_TYPE:
            begin
                phase_step = (in_byte == REC_TYPE_HANDSHAKE) ? PH_MAJOR : PH_DONE;
            end
            PH_MAJOR:
            begin
                if (in_byte == REC_MAJOR_VERSION)
                begin
                    skip_step  = HDR_REST_BYTES;
                    bpos_step  = 2'd0;
                    acc_step   = 16'd0;
                    phase_step = PH_HDR_REST;
                end
                else
                begin
                    phase_step = PH_DONE;
                end
            end
            PH_HS_TYPE:
            begin
                if (in_byte == HS_CLIENT_HELLO)
                begin
                    skip_step  = FIXED_BYTES;
                    bpos_step  = 2'd0;
                    acc_step   = 16'd0;
                    phase_step = PH_FIXED;
                end
                else
                begin
                    phase_step = PH_DONE;
                end
            end
            PH_HDR_REST, PH_FIXED, PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP:
            begin
                skip_step = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    unique case (phase_reg)
                        PH_HDR_REST: phase_step = PH_HS_TYPE;
                        PH_FIXED:    phase_step = PH_SID_LEN;
                        PH_SID_SKIP: phase_step = PH_CS_LEN;
                        PH_CS_SKIP:  phase_step = PH_CM_LEN;
                        default:     phase_step = PH_EXT_LEN;
                    endcase
                end
            end
            PH_SID_LEN:
            begin
                skip_step  = {8'd0, in_byte};
                bpos_step  = 2'd0;
                acc_step   = 16'd0;
                phase_step = (in_byte == 8'd0) ? PH_CS_LEN : PH_SID_SKIP;
            end
            PH_CS_LEN:
            begin
                if (bpos_reg == 2'd0)
                begin
                    acc_step  = acc_sh;
                    bpos_step = 2'd1;
                end
                else
                begin
                    skip_step  = acc_sh;
                    bpos_step  = 2'd0;
                    acc_step   = 16'd0;
                    phase_step = (acc_sh == 16'd0) ? PH_CM_LEN : PH_CS_SKIP;
                end
            end
            PH_CM_LEN:
            begin
                skip_step  = {8'd0, in_byte};
                bpos_step  = 2'd0;
                acc_step   = 16'd0;
                phase_step = (in_byte == 8'd0) ? PH_EXT_LEN : PH_CM_SKIP;
            end
            PH_EXT_LEN:
            begin
                ext_step = ext_sh;
                if (bpos_reg == 2'd0)
                begin
                    bpos_step = 2'd1;
                end
                else
                begin
                    bpos_step = 2'd0;
                    if (ext_sh >= 16'd4)
                    begin
                        phase_step = PH_EXT_HDR;
                        acc_step   = 16'd0;
                        skip_step  = 16'd0;
                    end
                    else
                    begin
                        phase_step = PH_DONE;
                    end
                end
            end
            PH_EXT_HDR:
            begin
                ext_step = ext_dec;
                if (bpos_reg < 2'd2)
                    acc_step = acc_sh;
                else
                    skip_step = skip_sh;
                if (bpos_reg != 2'd3)
                begin
                    bpos_step = bpos_reg + 2'd1;
                end
                else if (acc_reg == EXT_SERVER_NAME)
                begin
                    bpos_step  = 2'd0;
                    acc_step   = 16'd0;
                    phase_step = (ext_dec >= 16'd5) ? PH_SNI_HDR : PH_DONE;
                end
                else if (skip_sh == 16'd0)
                begin
                    // zero-length extension: straight to the next header, or done if none fits
                    if (ext_dec >= 16'd4)
                    begin
                        phase_step = PH_EXT_HDR;
                        bpos_step  = 2'd0;
                        acc_step   = 16'd0;
                        skip_step  = 16'd0;
                    end
                    else
                    begin
                        phase_step = PH_DONE;
                    end
                end
                else
                begin
                    phase_step = PH_EXT_SKIP;
                end
            end
            PH_EXT_SKIP:
            begin
                ext_step  = ext_dec;
                skip_step = skip_dec;
                if (ext_dec == 16'd0)
                begin
                    phase_step = PH_DONE;
                end
                else if (skip_dec == 16'd0)
                begin
                    if (ext_dec >= 16'd4)
                    begin
                        phase_step = PH_EXT_HDR;
                        bpos_step  = 2'd0;
                        acc_step   = 16'd0;
                        skip_step  = 16'd0;
                    end
                    else
                    begin
                        phase_step = PH_DONE;
                    end
                end
            end
            PH_SNI_HDR:
            begin
                // list length (2) and name type (1)
                ext_step = ext_dec;
                if (bpos_reg < 2'd2)
                begin
                    bpos_step = bpos_reg + 2'd1;
                end
                else
                begin
                    bpos_step  = 2'd0;
                    acc_step   = 16'd0;
                    phase_step = PH_SNI_LEN;
                end
            end
            PH_SNI_LEN:
            begin
                ext_step = ext_dec;
                acc_step = acc_sh;
                if (bpos_reg == 2'd0)
                begin
                    bpos_step = 2'd1;
                end
                else if (acc_sh <= MAX_NAME_BYTES)
                begin
                    found_step = 1'b1;
                    nlen_step  = acc_sh[7:0];
                    nleft_step = acc_sh[7:0];
                    phase_step = (acc_sh[7:0] == 8'd0 || ext_dec == 16'd0) ? PH_DONE : PH_NAME;
                end
                else
                begin
                    phase_step = PH_DONE;
                end
            end
            PH_NAME:
            begin
                ext_step   = ext_dec;
                nleft_step = nleft_dec;
                emit_name  = 1'b1;
                if (nleft_dec == 8'd0 || ext_dec == 16'd0)
                    phase_step = PH_DONE;
            end
            default:
            begin
                phase_step = PH_DONE;
            end
        endcase
    end

    // Build the results from the updated state, then rearm on the last byte.
    always_comb
    begin
        res = '0;
        if (in_valid)
        begin
            if (emit_name)
            begin
                res.v0           = 1'b1;
                res.r0.name_byte = in_byte;
                if (in_last)
                begin
                    res.v1            = 1'b1;
                    res.r1.kind       = 1'b1;
                    res.r1.sni_found  = found_step;
                    res.r1.sni_length = found_step ? nlen_step : 8'd0;
                    res.r1.truncated  = found_step && (nleft_step != 8'd0);
                    res.r1.is_last    = 1'b1;
                end
            end
            else if (in_last)
            begin
                res.v0            = 1'b1;
                res.r0.kind       = 1'b1;
                res.r0.sni_found  = found_step;
                res.r0.sni_length = found_step ? nlen_step : 8'd0;
                res.r0.truncated  = found_step && (nleft_step != 8'd0);
                res.r0.is_last    = 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bpos_next  = bpos_reg;
        skip_next  = skip_reg;
        acc_next   = acc_reg;
        ext_next   = ext_reg;
        nleft_next = nleft_reg;
        nlen_next  = nlen_reg;
        found_next = found_reg;
        if (in_valid && in_last)
        begin
            phase_next = PH_TYPE;
            bpos_next  = 2'd0;
            skip_next  = 16'd0;
            acc_next   = 16'd0;
            ext_next   = 16'd0;
            nleft_next = 8'd0;
            nlen_next  = 8'd0;
            found_next = 1'b0;
        end
        else if (in_valid)
        begin
            phase_next = phase_step;
            bpos_next  = bpos_step;
            skip_next  = skip_step;
            acc_next   = acc_step;
            ext_next   = ext_step;
            nleft_next = nleft_step;
            nlen_next  = nlen_step;
            found_next = found_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            bpos_reg  <= 2'd0;
            skip_reg  <= 16'd0;
            acc_reg   <= 16'd0;
            ext_reg   <= 16'd0;
            nleft_reg <= 8'd0;
            nlen_reg  <= 8'd0;
            found_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bpos_reg  <= bpos_next;
            skip_reg  <= skip_next;
            acc_reg   <= acc_next;
            ext_reg   <= ext_next;
            nleft_reg <= nleft_next;
            nlen_reg  <= nlen_next;
            found_reg <= found_next;
        end
    end

    `TLSSNI_ASSERT_IMP(a_pair_order, res.v1, res.v0 && !res.r0.is_last && res.r1.is_last, "second result must be a summary after a name byte")
    `TLSSNI_ASSERT_NXT(a_last_rearm, in_valid && in_last, phase_reg == PH_TYPE && !found_reg, "parser not rearmed after last byte")
    `TLSSNI_ASSERT_IMP(a_name_needs_found, res.v0 && !res.r0.kind, found_reg, "name byte emitted without accepted length")

endmodule

// ===== rtl/tlssni_out_fifo.sv =====
// Four-entry queue taking up to two results per cycle, one out on out_ready.
`timescale 1ns / 1ps
`include "tls_client_hello_sni_extract_core_assert.svh"
module tlssni_out_fifo
    import tlssni_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_pair_t push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    out_item_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [1:0]         push_cnt;
    logic               pop;

    assign room       = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_item   = mem[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign push_cnt   = {1'b0, push.v0} + {1'b0, push.v1};
    assign wr_ptr_inc = wr_ptr_reg + FIFO_AW'(1);

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
    assign rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
    assign count_next  = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.v0)
            mem[wr_ptr_reg] <= push.r0;
        if (push.v1)
            mem[wr_ptr_inc] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TLSSNI_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FIFO_CW'(FIFO_DEPTH), "result queue count out of range")
    `TLSSNI_ASSERT_IMP(a_no_overflow, push.v0, count_reg <= FIFO_CW'(FIFO_DEPTH - 2), "push without room for two results")
    `TLSSNI_ASSERT_NXT(a_idle_hold, !push.v0 && !pop, $stable(count_reg), "queue count moved without push or pop")

endmodule

// ===== dv/tls_client_hello_sni_extract_core_tb.sv =====
// Self-checking stream testbench for the TLS ClientHello server-name extractor.
`timescale 1ns / 1ps
module tls_client_hello_sni_extract_core_tb;
    import tlssni_pkg::*;

    localparam int     CLK_HALF     = 1;
    localparam int     RESET_CYCLES = 7;
    localparam int     ITEM_TARGET  = 500;    // packet bytes from ClientHello shapes
    localparam int     DRAIN_CYCLES = 20;     // queue depth plus latency, with margin
    localparam int     HOLD_CYCLES  = 64;     // long receiver hold-off
    localparam longint CYCLE_LIMIT  = 400000;
    localparam int     DIR_ROWS     = 21;

    // Packet shapes. Every shape but noise is a ClientHello with random content;
    // the name of the shape says which corner of the parser it aims at.
    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_EMPTY_NAME,
        SHAPE_LONG_NAME,
        SHAPE_PAST_BLOCK,
        SHAPE_MAX_NAME,
        SHAPE_CUT_NAME,
        SHAPE_CUT_ANY,
        SHAPE_SHORT_BLOCK,
        SHAPE_TWO_SNI,
        SHAPE_SKIP_RUNOUT,
        SHAPE_NOISE
    } hello_shape_t;
    localparam int NUM_SHAPES = 11;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;    // 1: want holds the summary to check against
        out_item_t  want;
    } stim_row_t;

    // Summary of a packet that never reached a server name.
    localparam out_item_t NO_SNI = '{kind: 1'b1, name_byte: 8'h00, sni_found: 1'b0,
                                     sni_length: 8'h00, truncated: 1'b0, is_last: 1'b1};

    // Idle profiles, cycled per packet: none, sender only, receiver only, both.
    int tx_idle_tbl [4] = '{0, 47, 0, 18};
    int rx_stall_tbl [4] = '{0, 0, 47, 18};

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    tls_client_hello_sni_extract_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Directed packets: wrong record types at both byte extremes, a packet
    // ending after the type, a wrong major version, a server hello, a packet
    // ending inside the fixed fields, and a short non-handshake packet.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, NO_SNI},
        '{8'hFF, 1'b1, 1'b1, NO_SNI},
        '{8'h16, 1'b1, 1'b1, NO_SNI},
        '{8'h16, 1'b0, 1'b0, '0},
        '{8'h02, 1'b1, 1'b1, NO_SNI},
        '{8'h16, 1'b0, 1'b0, '0},
        '{8'h03, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h40, 1'b0, 1'b0, '0},
        '{8'h02, 1'b1, 1'b1, NO_SNI},
        '{8'h16, 1'b0, 1'b0, '0},
        '{8'h03, 1'b0, 1'b0, '0},
        '{8'h03, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, NO_SNI},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b1, 1'b1, NO_SNI}
    };

    // Expected output transactions, oldest first.
    out_item_t    sni_results_due [$];
    logic [7:0]   hello_q [$];    // packet under construction
    logic [7:0]   ext_q [$];      // its extension block

    int           tx_idle_pct  = 0;
    int           rx_stall_pct = 0;
    hello_shape_t cur_shape    = SHAPE_NOISE;

    int mismatches    = 0;
    int packets_sent  = 0;
    int bytes_sent    = 0;
    int name_bytes    = 0;
    int summaries     = 0;
    int found_names   = 0;
    int trunc_names   = 0;
    int input_stalls  = 0;
    int hold_applied  = 0;

    // ---------------------------------------------------------------------
    // Parser prediction: mirrors the packet walk byte by byte.
    // ---------------------------------------------------------------------
    phase_t      prs_phase;
    logic [2:0]  fld_idx;
    logic [15:0] skip_left;
    logic [15:0] field_acc;
    logic [15:0] ext_left;
    logic [7:0]  name_left;
    logic [7:0]  len_seen;
    logic        sni_seen;
    out_item_t   step_res [2];
    int          step_cnt;

    task automatic rearm_parser();
        prs_phase = PH_TYPE;
        fld_idx   = '0;
        skip_left = '0;
        field_acc = '0;
        ext_left  = '0;
        name_left = '0;
        len_seen  = '0;
        sni_seen  = 1'b0;
    endtask

    task automatic start_skip(input phase_t skip_ph, input phase_t after_ph,
                              input logic [15:0] count);
        skip_left = count;
        fld_idx   = '0;
        field_acc = '0;
        prs_phase = (count == 16'd0) ? after_ph : skip_ph;
    endtask

    // Move to the next extension header if one still fits in the block.
    task automatic next_extension();
        if (ext_left >= 16'd4)
        begin
            prs_phase = PH_EXT_HDR;
            fld_idx   = '0;
            field_acc = '0;
            skip_left = '0;
        end
        else
        begin
            prs_phase = PH_DONE;
        end
    endtask

    task automatic parse_sni_byte(input logic [7:0] b, input logic last);
        out_item_t r;
        step_cnt = 0;
        case (prs_phase)
            PH_TYPE:
                prs_phase = (b == REC_TYPE_HANDSHAKE) ? PH_MAJOR : PH_DONE;
            PH_MAJOR:
                if (b == REC_MAJOR_VERSION)
                    start_skip(PH_HDR_REST, PH_HS_TYPE, HDR_REST_BYTES);
                else
                    prs_phase = PH_DONE;
            PH_HS_TYPE:
                if (b == HS_CLIENT_HELLO)
                    start_skip(PH_FIXED, PH_SID_LEN, FIXED_BYTES);
                else
                    prs_phase = PH_DONE;
            PH_HDR_REST, PH_FIXED, PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP:
            begin
                skip_left = skip_left - 16'd1;
                // one-hot: the phase after each skip is the next bit up
                if (skip_left == 16'd0)
                    prs_phase = phase_t'(prs_phase << 1);
            end
            PH_SID_LEN:
                start_skip(PH_SID_SKIP, PH_CS_LEN, {8'h00, b});
            PH_CS_LEN:
            begin
                field_acc = {field_acc[7:0], b};
                if (fld_idx == 3'd0)
                    fld_idx = 3'd1;
                else
                    start_skip(PH_CS_SKIP, PH_CM_LEN, field_acc);
            end
            PH_CM_LEN:
                start_skip(PH_CM_SKIP, PH_EXT_LEN, {8'h00, b});
            PH_EXT_LEN:
            begin
                ext_left = {ext_left[7:0], b};
                if (fld_idx == 3'd0)
                begin
                    fld_idx = 3'd1;
                end
                else
                begin
                    fld_idx = 3'd0;
                    next_extension();
                end
            end
            PH_EXT_HDR:
            begin
                ext_left = ext_left - 16'd1;
                if (fld_idx < 3'd2)
                    field_acc = {field_acc[7:0], b};
                else
                    skip_left = {skip_left[7:0], b};
                if (fld_idx < 3'd3)
                begin
                    fld_idx = fld_idx + 3'd1;
                end
                else if (field_acc == EXT_SERVER_NAME)
                begin
                    fld_idx   = '0;
                    field_acc = '0;
                    prs_phase = (ext_left >= 16'd5) ? PH_SNI_HDR : PH_DONE;
                end
                else if (skip_left == 16'd0)
                begin
                    next_extension();
                end
                else
                begin
                    prs_phase = PH_EXT_SKIP;
                end
            end
            PH_EXT_SKIP:
            begin
                ext_left  = ext_left - 16'd1;
                skip_left = skip_left - 16'd1;
                if (ext_left == 16'd0)
                    prs_phase = PH_DONE;
                else if (skip_left == 16'd0)
                    next_extension();
            end
            PH_SNI_HDR:
            begin
                // list length and name type are passed over
                ext_left = ext_left - 16'd1;
                if (fld_idx < 3'd2)
                begin
                    fld_idx = fld_idx + 3'd1;
                end
                else
                begin
                    fld_idx   = '0;
                    field_acc = '0;
                    prs_phase = PH_SNI_LEN;
                end
            end
            PH_SNI_LEN:
            begin
                ext_left  = ext_left - 16'd1;
                field_acc = {field_acc[7:0], b};
                if (fld_idx == 3'd0)
                begin
                    fld_idx = 3'd1;
                end
                else if (field_acc <= MAX_NAME_BYTES)
                begin
                    sni_seen  = 1'b1;
                    len_seen  = field_acc[7:0];
                    name_left = field_acc[7:0];
                    prs_phase = (name_left == 8'd0 || ext_left == 16'd0) ? PH_DONE : PH_NAME;
                end
                else
                begin
                    prs_phase = PH_DONE;
                end
            end
            PH_NAME:
            begin
                ext_left  = ext_left - 16'd1;
                name_left = name_left - 8'd1;
                r           = '0;
                r.name_byte = b;
                step_res[step_cnt] = r;
                step_cnt++;
                if (name_left == 8'd0 || ext_left == 16'd0)
                    prs_phase = PH_DONE;
            end
            default:
                prs_phase = PH_DONE;
        endcase

        if (last)
        begin
            r            = '0;
            r.kind       = 1'b1;
            r.sni_found  = sni_seen;
            r.sni_length = sni_seen ? len_seen : 8'd0;
            r.truncated  = sni_seen && (name_left != 8'd0);
            r.is_last    = 1'b1;
            step_res[step_cnt] = r;
            step_cnt++;
            rearm_parser();
        end
    endtask

    // ---------------------------------------------------------------------
    // Packet construction.
    // ---------------------------------------------------------------------
    task automatic push_rand(input int count);
        repeat (count) hello_q.push_back(8'($urandom));
    endtask

    task automatic ext_push16(input logic [15:0] v);
        ext_q.push_back(v[15:8]);
        ext_q.push_back(v[7:0]);
    endtask

    // Any extension other than server name, with len bytes of data.
    task automatic add_other_ext(input int len);
        logic [15:0] other_id;
        other_id = 16'($urandom);
        if (other_id == EXT_SERVER_NAME)
            other_id = 16'h000a;
        ext_push16(other_id);
        ext_push16(16'(len));
        repeat (len) ext_q.push_back(8'($urandom));
    endtask

    // Server-name extension declaring decl_len, followed by carried name bytes.
    task automatic add_sni_ext(input int decl_len, input int carried);
        ext_push16(EXT_SERVER_NAME);
        ext_push16(16'(5 + carried));
        ext_push16(16'(3 + carried));
        ext_q.push_back(8'h00);
        ext_push16(16'(decl_len));
        repeat (carried) ext_q.push_back(8'($urandom));
    endtask

    task automatic build_packet(input hello_shape_t shape);
        int          host_len;
        int          pre_end;
        int          name_end;
        int          sid_len;
        int          cs_len;
        int          cm_len;
        int          cut;
        logic [15:0] decl_len;
        hello_q.delete();
        ext_q.delete();

        if (shape == SHAPE_NOISE)
        begin
            push_rand($urandom_range(1, 24));
            if ($urandom_range(1) == 1)
                hello_q[0] = REC_TYPE_HANDSHAKE;
            if (hello_q.size() > 1 && $urandom_range(1) == 1)
                hello_q[1] = REC_MAJOR_VERSION;
            return;
        end

        case (shape)
            SHAPE_EMPTY_NAME:                  host_len = 0;
            SHAPE_MAX_NAME:                    host_len = 255;
            SHAPE_LONG_NAME:                   host_len = $urandom_range(256, 65535);
            SHAPE_PAST_BLOCK, SHAPE_CUT_NAME:  host_len = $urandom_range(4, 24);
            default:
                host_len = ($urandom_range(9) == 0) ? $urandom_range(25, 60)
                                                     : $urandom_range(1, 24);
        endcase

        // extension block
        if (shape == SHAPE_SKIP_RUNOUT)
            add_other_ext($urandom_range(2, 6));
        else
            repeat ($urandom_range(0, 2)) add_other_ext($urandom_range(0, 6));
        pre_end = ext_q.size();
        add_sni_ext(host_len, (shape == SHAPE_LONG_NAME) ? 6 : host_len);
        name_end = ext_q.size();
        if (shape == SHAPE_TWO_SNI)
            add_sni_ext($urandom_range(1, 8), 8);
        else if (shape != SHAPE_CUT_NAME && $urandom_range(1) == 1)
            add_other_ext($urandom_range(0, 6));

        case (shape)
            SHAPE_PAST_BLOCK:
                decl_len = 16'(name_end - $urandom_range(1, host_len - 1));
            SHAPE_SKIP_RUNOUT:
                decl_len = 16'($urandom_range(5, pre_end - 1));
            SHAPE_SHORT_BLOCK:
                decl_len = ($urandom_range(1) == 1) ? 16'($urandom_range(0, 3))
                                                     : 16'(pre_end + 4 + $urandom_range(0, 4));
            default:
                decl_len = 16'(ext_q.size());
        endcase

        // record header, handshake type, length, version, random
        hello_q.push_back(REC_TYPE_HANDSHAKE);
        hello_q.push_back(REC_MAJOR_VERSION);
        push_rand(3);
        hello_q.push_back(HS_CLIENT_HELLO);
        push_rand(37);
        sid_len = ($urandom_range(7) == 0) ? 32 : $urandom_range(0, 4);
        hello_q.push_back(8'(sid_len));
        push_rand(sid_len);
        cs_len = 2 * $urandom_range(0, 3);
        hello_q.push_back(8'h00);
        hello_q.push_back(8'(cs_len));
        push_rand(cs_len);
        cm_len = $urandom_range(0, 2);
        hello_q.push_back(8'(cm_len));
        push_rand(cm_len);
        hello_q.push_back(decl_len[15:8]);
        hello_q.push_back(decl_len[7:0]);
        foreach (ext_q[i])
            hello_q.push_back(ext_q[i]);

        // The name is last in a cut-name packet, so dropping fewer bytes than
        // its length ends the packet inside the name.
        if (shape == SHAPE_CUT_NAME)
            cut = $urandom_range(1, host_len - 1);
        else if (shape == SHAPE_CUT_ANY)
            cut = $urandom_range(1, hello_q.size() - 2);
        else
            cut = 0;
        repeat (cut) void'(hello_q.pop_back());
    endtask

    function automatic hello_shape_t pick_shape();
        int r;
        r = $urandom_range(99);
        if (r < 45) return SHAPE_CLEAN;
        if (r < 52) return SHAPE_EMPTY_NAME;
        if (r < 59) return SHAPE_LONG_NAME;
        if (r < 66) return SHAPE_PAST_BLOCK;
        if (r < 73) return SHAPE_CUT_NAME;
        if (r < 80) return SHAPE_CUT_ANY;
        if (r < 85) return SHAPE_SHORT_BLOCK;
        if (r < 90) return SHAPE_TWO_SNI;
        if (r < 95) return SHAPE_SKIP_RUNOUT;
        return SHAPE_NOISE;
    endfunction

    // Offer one byte, hold it until accepted, then queue what it should produce.
    // A typed row overrides the predicted summary with the one written in the table.
    task automatic offer_byte(input logic [7:0] b, input logic last,
                              input logic typed, input out_item_t want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        parse_sni_byte(b, last);
        if (typed)
        begin
            sni_results_due.push_back(want);
        end
        else
        begin
            for (int i = 0; i < step_cnt; i++)
                sni_results_due.push_back(step_res[i]);
        end
        bytes_sent++;
        if (last)
            packets_sent++;
    endtask

    function automatic void check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatches++;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Clock, watchdog, receiver, checker.
    // ---------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding",
                 CYCLE_LIMIT, sni_results_due.size());
        $display("tls_client_hello_sni_extract_core: mismatch");
        $finish;
    end

    // Receiver: random stalls per the current profile; once, as soon as output
    // shows up during the longest-name packet, hold off for a long stretch so
    // the output queue fills and the input side backs up.
    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && cur_shape == SHAPE_MAX_NAME && m_axis_tvalid)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                hold_applied++;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Compare each output transaction, field by field, with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && s_axis_tvalid && !s_axis_tready)
            input_stalls++;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sni_results_due.size() == 0)
            begin
                $error("unexpected result: tdata 0x%0h tuser %0b tlast %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = sni_results_due.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("name_byte", want.name_byte, m_axis_tdata[7:0]);
                check_field("sni_found", want.sni_found, m_axis_tdata[8]);
                check_field("sni_length", want.sni_length, m_axis_tdata[16:9]);
                check_field("truncated", want.truncated, m_axis_tdata[17]);
                check_field("is_last", want.is_last, m_axis_tlast);
                if (want.kind)
                begin
                    summaries++;
                    if (want.sni_found)
                        found_names++;
                    if (want.truncated)
                        trunc_names++;
                end
                else
                begin
                    name_bytes++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus: reset, directed table, then shaped random packets.
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        hello_shape_t shape;
        int           gen_no;
        int           useful_bytes;
        gen_no        = 0;
        useful_bytes  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        rearm_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

        // Walk every shape once, then draw shapes at random until enough
        // ClientHello bytes have gone in.
        while (gen_no < NUM_SHAPES || useful_bytes < ITEM_TARGET)
        begin
            shape = (gen_no < NUM_SHAPES) ? hello_shape_t'(gen_no) : pick_shape();
            tx_idle_pct  = tx_idle_tbl[gen_no % 4];
            rx_stall_pct = rx_stall_tbl[gen_no % 4];
            // now and then, drop valid and wait for the output side to drain
            if (gen_no % 5 == 3)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (sni_results_due.size() != 0)
                    @(posedge clk);
            end
            cur_shape = shape;
            build_packet(shape);
            foreach (hello_q[k])
                offer_byte(hello_q[k], k == hello_q.size() - 1, 1'b0, '0);
            if (shape != SHAPE_NOISE)
                useful_bytes += hello_q.size();
            gen_no++;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sni_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d packets (%0d bytes); checked %0d name bytes and %0d summaries",
                 packets_sent, bytes_sent, name_bytes, summaries);
        $display("  %0d with a name, %0d truncated; input backed up %0d cycles, hold %0d",
                 found_names, trunc_names, input_stalls, hold_applied);
        if (mismatches == 0)
            $display("tls_client_hello_sni_extract_core: match");
        else
            $display("tls_client_hello_sni_extract_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tlssni_pkg.sv
rtl/tlssni_parser.sv
rtl/tlssni_out_fifo.sv
rtl/tls_client_hello_sni_extract_core.sv
dv/tls_client_hello_sni_extract_core_tb.sv
